[sv/uyvy_to_nv12_converter_top_assert.svh]
// ----------------------------------------------------------------------------
// uyvy to nv12 converter assertion macros
// shared immediate-consequence and next-cycle property wrappers
// ----------------------------------------------------------------------------
`ifndef UYVY_TO_NV12_CONVERTER_TOP_ASSERT_SVH
`define UYVY_TO_NV12_CONVERTER_TOP_ASSERT_SVH

// same-cycle implication
`define U2N_AST_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define U2N_AST_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/u2n_pkg.sv]
// ----------------------------------------------------------------------------
// u2n_pkg
// shared widths, register indexes and pipeline types of the converter
// ----------------------------------------------------------------------------
`default_nettype none

package u2n_pkg;

  localparam int BYTE_W       = 8;
  localparam int LUMA_ROW_W   = 12;
  localparam int PAIR_COL_W   = 11;
  localparam int CHROMA_ROW_W = 11;
  localparam int PAIRS_REG_W  = 12;
  localparam int ROWS_REG_W   = 13;
  localparam int CFG_AW       = 3;
  localparam int CFG_DW       = 32;
  localparam int LINE_W       = 2 * BYTE_W;

  localparam logic [15:0] BYTE_MASK = 16'h00FF;

  // register index, taken from paddr[2]
  localparam logic REG_PAIRS = 1'b0;
  localparam logic REG_ROWS  = 1'b1;

  typedef logic [BYTE_W-1:0] byte_t;

  // item held between the input register and the result register
  typedef struct packed {
    byte_t                   chroma_u;
    byte_t                   chroma_v;
    byte_t                   luma_first;
    byte_t                   luma_second;
    logic [LUMA_ROW_W-1:0]   luma_row;
    logic [PAIR_COL_W-1:0]   pair_column;
    logic [CHROMA_ROW_W-1:0] chroma_row;
    logic                    odd_row;
    logic                    last_row;
    logic                    frame_end;
  } s1_t;

  typedef struct packed {
    byte_t                   luma_first_out;
    byte_t                   luma_second_out;
    logic [LUMA_ROW_W-1:0]   luma_row;
    logic [PAIR_COL_W-1:0]   pair_column;
    logic                    chroma_valid;
    byte_t                   chroma_u_out;
    byte_t                   chroma_v_out;
    logic [CHROMA_ROW_W-1:0] chroma_row;
    logic                    frame_end;
  } out_t;

endpackage

`default_nettype wire

[sv/u2n_if.sv]
// ----------------------------------------------------------------------------
// u2n channel interfaces
// valid/ready channels for uyvy macropixel beats and nv12 result beats
// ----------------------------------------------------------------------------
`default_nettype none

interface u2n_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] chroma_u_in;
  logic [7:0] luma_first_in;
  logic [7:0] chroma_v_in;
  logic [7:0] luma_second_in;

  modport source (output valid, output chroma_u_in, output luma_first_in,
                  output chroma_v_in, output luma_second_in, input ready);
  modport sink (input valid, input chroma_u_in, input luma_first_in,
                input chroma_v_in, input luma_second_in, output ready);
endinterface

interface u2n_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  luma_first_out;
  logic [7:0]  luma_second_out;
  logic [11:0] luma_row;
  logic [10:0] pair_column;
  logic        chroma_valid;
  logic [7:0]  chroma_u_out;
  logic [7:0]  chroma_v_out;
  logic [10:0] chroma_row;
  logic        frame_end;

  modport source (output valid, output luma_first_out, output luma_second_out,
                  output luma_row, output pair_column, output chroma_valid,
                  output chroma_u_out, output chroma_v_out, output chroma_row,
                  output frame_end, input ready);
  modport sink (input valid, input luma_first_out, input luma_second_out,
                input luma_row, input pair_column, input chroma_valid,
                input chroma_u_out, input chroma_v_out, input chroma_row,
                input frame_end, output ready);
endinterface

`default_nettype wire

[sv/u2n_ram.sv]
// ----------------------------------------------------------------------------
// u2n_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module u2n_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[sv/u2n_cfg.sv]
// ----------------------------------------------------------------------------
// u2n_cfg
// apb register file for frame geometry, with range clamping
// ----------------------------------------------------------------------------
`default_nettype none

module u2n_cfg
  import u2n_pkg::*;
#(
  parameter int MAX_PAIRS = 2048,
  parameter int MAX_ROWS  = 4096
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [CFG_AW-1:0]                paddr,
  input  wire logic [CFG_DW-1:0]                pwdata,
  output logic      [CFG_DW-1:0]                prdata,
  output logic                                  pready,
  output logic      [$clog2(MAX_PAIRS+1)-1:0]   pairs_eff,
  output logic      [$clog2(MAX_ROWS+1)-1:0]    rows_eff
);

  localparam int PW  = $clog2(MAX_PAIRS + 1);
  localparam int RWE = $clog2(MAX_ROWS + 1);

  logic [PAIRS_REG_W-1:0] pairs_r, pairs_nxt;
  logic [ROWS_REG_W-1:0]  rows_r, rows_nxt;
  logic                   wr_stb;

  assign pready = 1'b1;
  assign wr_stb = psel && penable && pwrite && pready;

  always_comb begin
    pairs_nxt = pairs_r;
    rows_nxt  = rows_r;
    if (wr_stb) begin
      case (paddr[2])
        REG_PAIRS: pairs_nxt = pwdata[PAIRS_REG_W-1:0];
        REG_ROWS:  rows_nxt  = pwdata[ROWS_REG_W-1:0];
        default:   pairs_nxt = pairs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pairs_r <= PAIRS_REG_W'(960);
      rows_r  <= ROWS_REG_W'(1080);
    end else begin
      pairs_r <= pairs_nxt;
      rows_r  <= rows_nxt;
    end
  end

  always_comb begin
    case (paddr[2])
      REG_PAIRS: prdata = CFG_DW'(pairs_r);
      REG_ROWS:  prdata = CFG_DW'(rows_r);
      default:   prdata = '0;
    endcase
  end

  // zero acts as one, oversize acts as the maximum
  always_comb begin
    if (pairs_r == '0) begin
      pairs_eff = PW'(1);
    end else if (32'(pairs_r) > 32'(MAX_PAIRS)) begin
      pairs_eff = PW'(MAX_PAIRS);
    end else begin
      pairs_eff = PW'(pairs_r);
    end
    if (rows_r == '0) begin
      rows_eff = RWE'(1);
    end else if (32'(rows_r) > 32'(MAX_ROWS)) begin
      rows_eff = RWE'(MAX_ROWS);
    end else begin
      rows_eff = RWE'(rows_r);
    end
  end

endmodule

`default_nettype wire

[sv/u2n_seq.sv]
// ----------------------------------------------------------------------------
// u2n_seq
// raster counters, chroma line buffer access and input register stage
// ----------------------------------------------------------------------------
`default_nettype none
`include "uyvy_to_nv12_converter_top_assert.svh"

module u2n_seq
  import u2n_pkg::*;
#(
  parameter int MAX_PAIRS = 2048,
  parameter int MAX_ROWS  = 4096
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic [$clog2(MAX_PAIRS+1)-1:0] pairs_eff,
  input  wire logic [$clog2(MAX_ROWS+1)-1:0]  rows_eff,
  u2n_in_if.sink                              in_ch,
  input  wire logic                           s1_ready,
  output logic                                s1_valid,
  output s1_t                                 s1,
  output logic      [LINE_W-1:0]              held
);

  localparam int CW = $clog2(MAX_PAIRS);
  localparam int RW = $clog2(MAX_ROWS);

  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW:0]   col_inc;
  logic [RW:0]   row_inc;
  logic          last_col, last_row, frame_end_now;
  logic          accept;
  logic          s1_valid_r, s1_valid_nxt;
  s1_t           s1_r;
  logic          wr_en, rd_en;

  assign in_ch.ready = !s1_valid_r || s1_ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign col_inc       = {1'b0, col_r} + 1'b1;
  assign row_inc       = {1'b0, row_r} + 1'b1;
  assign last_col      = col_inc >= (CW+1)'(pairs_eff);
  assign last_row      = row_inc >= (RW+1)'(rows_eff);
  assign frame_end_now = last_col && last_row;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_inc[RW-1:0];
      end else begin
        col_nxt = col_inc[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // even rows store chroma, odd rows fetch it
  assign wr_en = accept && !row_r[0];
  assign rd_en = accept && row_r[0];

  u2n_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_PAIRS)
  ) u_line (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (col_r),
    .wr_data ({in_ch.chroma_v_in, in_ch.chroma_u_in}),
    .rd_en   (rd_en),
    .rd_addr (col_r),
    .rd_data (held)
  );

  always_comb begin
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_ready) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r.chroma_u    <= in_ch.chroma_u_in;
      s1_r.chroma_v    <= in_ch.chroma_v_in;
      s1_r.luma_first  <= in_ch.luma_first_in;
      s1_r.luma_second <= in_ch.luma_second_in;
      s1_r.luma_row    <= LUMA_ROW_W'(row_r);
      s1_r.pair_column <= PAIR_COL_W'(col_r);
      s1_r.chroma_row  <= CHROMA_ROW_W'(row_r >> 1);
      s1_r.odd_row     <= row_r[0];
      s1_r.last_row    <= last_row;
      s1_r.frame_end   <= frame_end_now;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1       = s1_r;

  `U2N_AST_NXT(a_frame_wrap, clk, rst_n, accept && frame_end_now, col_r == '0 && row_r == '0, "counters did not wrap at frame end")
  `U2N_AST_NXT(a_col_step, clk, rst_n, accept && !last_col, col_r == $past(col_r) + 1'b1 && row_r == $past(row_r), "column did not advance within row")
  `U2N_AST_NXT(a_s1_hold, clk, rst_n, s1_valid_r && !s1_ready, s1_valid_r && $stable(s1_r) && (!s1_r.odd_row || $stable(held)), "stalled stage or line data changed")

endmodule

`default_nettype wire

[sv/u2n_out.sv]
// ----------------------------------------------------------------------------
// u2n_out
// chroma averaging and result register
// ----------------------------------------------------------------------------
`default_nettype none
`include "uyvy_to_nv12_converter_top_assert.svh"

module u2n_out
  import u2n_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              s1_valid,
  input  wire s1_t               s1,
  input  wire logic [LINE_W-1:0] held,
  output logic                   s1_ready,
  u2n_out_if.source              out_ch
);

  logic  out_valid_r, out_valid_nxt;
  out_t  out_r, res;
  logic  load;
  byte_t held_u, held_v;

  function automatic byte_t avg_up(input byte_t a, input byte_t b);
    logic [BYTE_W:0] sum;
    sum = {1'b0, a} + {1'b0, b} + 1'b1;
    return sum[BYTE_W:1];
  endfunction

  assign held_u = held[BYTE_W-1:0];
  assign held_v = held[LINE_W-1:BYTE_W];

  assign s1_ready = !out_valid_r || out_ch.ready;
  assign load     = s1_valid && s1_ready;

  always_comb begin
    res.luma_first_out  = s1.luma_first;
    res.luma_second_out = s1.luma_second;
    res.luma_row        = s1.luma_row;
    res.pair_column     = s1.pair_column;
    res.frame_end       = s1.frame_end;
    res.chroma_valid    = 1'b0;
    res.chroma_u_out    = '0;
    res.chroma_v_out    = '0;
    res.chroma_row      = '0;
    if (s1.odd_row) begin
      res.chroma_valid = 1'b1;
      res.chroma_u_out = avg_up(held_u, s1.chroma_u);
      res.chroma_v_out = avg_up(held_v, s1.chroma_v);
      res.chroma_row   = s1.chroma_row;
    end else if (s1.last_row) begin
      // odd height: last row pairs with itself
      res.chroma_valid = 1'b1;
      res.chroma_u_out = avg_up(s1.chroma_u, s1.chroma_u);
      res.chroma_v_out = avg_up(s1.chroma_v, s1.chroma_v);
      res.chroma_row   = s1.chroma_row;
    end
  end

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= res;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.luma_first_out  = out_r.luma_first_out;
  assign out_ch.luma_second_out = out_r.luma_second_out;
  assign out_ch.luma_row        = out_r.luma_row;
  assign out_ch.pair_column     = out_r.pair_column;
  assign out_ch.chroma_valid    = out_r.chroma_valid;
  assign out_ch.chroma_u_out    = out_r.chroma_u_out;
  assign out_ch.chroma_v_out    = out_r.chroma_v_out;
  assign out_ch.chroma_row      = out_r.chroma_row;
  assign out_ch.frame_end       = out_r.frame_end;

  `U2N_AST_IMP(a_no_chroma_zero, clk, rst_n, out_valid_r && !out_r.chroma_valid, out_r.chroma_u_out == '0 && out_r.chroma_v_out == '0 && out_r.chroma_row == '0, "chroma fields not cleared without chroma")
  `U2N_AST_IMP(a_chroma_row, clk, rst_n, out_valid_r && out_r.chroma_valid, out_r.chroma_row == out_r.luma_row[LUMA_ROW_W-1:1], "chroma row does not follow luma row")
  `U2N_AST_IMP(a_end_chroma, clk, rst_n, out_valid_r && out_r.frame_end, out_r.chroma_valid, "frame end beat carries no chroma")

endmodule

`default_nettype wire

[sv/uyvy_to_nv12_converter_top.sv]
// ----------------------------------------------------------------------------
// uyvy_to_nv12_converter_top
// uyvy 4:2:2 macropixel stream to nv12 4:2:0 luma and interleaved chroma
// ----------------------------------------------------------------------------
// in_ch takes one uyvy macropixel (u, y0, v, y1) per beat in raster order.
// out_ch gives one beat per macropixel: both luma bytes with row and pair
// column, plus on odd rows (and on the last row of an odd-height frame) a
// rounded u/v average and its chroma row; frame_end marks the last beat.
// frame geometry is set over the apb port (pairs_per_row at 0x0,
// rows_per_frame at 0x4) while the block is idle.
// beats pass the input, then the result register. throughput is one beat
// per clock unless out_ch stalls; the chroma line buffer has one write and
// one registered read port, and a macropixel uses at most one of them.
// reset (rst_n low, synchronous) clears the raster counters and empties
// both pipeline stages; the line buffer is not cleared.
// when out_ch stalls, the result register holds and the input register
// still accepts one more beat; in_ch.ready drops once both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module uyvy_to_nv12_converter_top
  import u2n_pkg::*;
#(
  parameter int MAX_PAIRS = 2048,
  parameter int MAX_ROWS  = 4096
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  u2n_in_if.sink                   in_ch,
  u2n_out_if.source                out_ch,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [CFG_AW-1:0]   paddr,
  input  wire logic [CFG_DW-1:0]   pwdata,
  output logic      [CFG_DW-1:0]   prdata,
  output logic                     pready
);

  logic [$clog2(MAX_PAIRS+1)-1:0] pairs_eff;
  logic [$clog2(MAX_ROWS+1)-1:0]  rows_eff;
  logic                           s1_valid;
  logic                           s1_ready;
  s1_t                            s1;
  logic [LINE_W-1:0]              held;

  u2n_cfg #(
    .MAX_PAIRS (MAX_PAIRS),
    .MAX_ROWS  (MAX_ROWS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .pairs_eff (pairs_eff),
    .rows_eff  (rows_eff)
  );

  u2n_seq #(
    .MAX_PAIRS (MAX_PAIRS),
    .MAX_ROWS  (MAX_ROWS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .pairs_eff (pairs_eff),
    .rows_eff  (rows_eff),
    .in_ch     (in_ch),
    .s1_ready  (s1_ready),
    .s1_valid  (s1_valid),
    .s1        (s1),
    .held      (held)
  );

  u2n_out u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .s1       (s1),
    .held     (held),
    .s1_ready (s1_ready),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

[tb/sv/u2n_nv12_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// u2n_nv12_checker
// watches the uyvy input beats and the apb writes, predicts the nv12 result
// beat of every accepted macropixel and compares it field by field with the
// beats that leave the converter
// ----------------------------------------------------------------------------
module u2n_nv12_checker
  import u2n_pkg::*;
#(
  parameter int MAX_PAIRS = 2048,
  parameter int MAX_ROWS  = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  u2n_in_if                 in_mon,
  u2n_out_if                out_mon,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output int                fail_count,
  output int                pending_count
);

  logic [PAIRS_REG_W-1:0] pairs_reg;
  logic [ROWS_REG_W-1:0]  rows_reg;
  logic [PAIR_COL_W-1:0]  col_cnt;
  logic [LUMA_ROW_W-1:0]  row_cnt;
  logic [LINE_W-1:0]      uv_line [MAX_PAIRS];
  out_t                   nv12_expected_q [$];
  int                     fails = 0;
  int                     pending = 0;

  assign fail_count    = fails;
  assign pending_count = pending;

  function automatic int clamp_len(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic byte_t round_avg(byte_t a, byte_t b);
    logic [BYTE_W:0] s;
    s = {1'b0, a} + {1'b0, b} + 1'b1;
    return s[BYTE_W:1];
  endfunction

  // advances the raster position and the chroma line, one macropixel
  function automatic out_t predict_nv12(logic [31:0] beat);
    byte_t             u, y0, v, y1;
    int                pairs, rows;
    logic              last_col, last_row;
    logic [LINE_W-1:0] held;
    out_t              r;
    {u, y0, v, y1} = beat;
    pairs    = clamp_len(int'(pairs_reg), MAX_PAIRS);
    rows     = clamp_len(int'(rows_reg), MAX_ROWS);
    last_col = (int'(col_cnt) + 1) >= pairs;
    last_row = (int'(row_cnt) + 1) >= rows;
    r = '0;
    r.luma_first_out  = y0;
    r.luma_second_out = y1;
    r.luma_row        = row_cnt;
    r.pair_column     = col_cnt;
    if (!row_cnt[0]) begin
      uv_line[col_cnt] = {v, u};
      if (last_row) begin
        r.chroma_valid = 1'b1;
        r.chroma_u_out = round_avg(u, u);
        r.chroma_v_out = round_avg(v, v);
      end
    end else begin
      held           = uv_line[col_cnt];
      r.chroma_valid = 1'b1;
      r.chroma_u_out = round_avg(held[BYTE_W-1:0], u);
      r.chroma_v_out = round_avg(held[LINE_W-1:BYTE_W], v);
    end
    if (r.chroma_valid) r.chroma_row = row_cnt[LUMA_ROW_W-1:1];
    r.frame_end = last_col && last_row;
    if (last_col) begin
      col_cnt = '0;
      row_cnt = last_row ? '0 : row_cnt + 1'b1;
    end else begin
      col_cnt = col_cnt + 1'b1;
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    out_t want;
    out_t pred;
    if (!rst_n) begin
      pairs_reg = 12'd960;
      rows_reg  = 13'd1080;
      col_cnt   = '0;
      row_cnt   = '0;
      nv12_expected_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_PAIRS) pairs_reg = pwdata[PAIRS_REG_W-1:0];
        else rows_reg = pwdata[ROWS_REG_W-1:0];
      end
      if (out_mon.valid && out_mon.ready) begin
        if (nv12_expected_q.size() == 0) begin
          $error("result beat at row %0d column %0d with nothing pending",
                 out_mon.luma_row, out_mon.pair_column);
          fails++;
        end else begin
          want = nv12_expected_q.pop_front();
          check_field("luma_first_out", want.luma_first_out, out_mon.luma_first_out);
          check_field("luma_second_out", want.luma_second_out, out_mon.luma_second_out);
          check_field("luma_row", want.luma_row, out_mon.luma_row);
          check_field("pair_column", want.pair_column, out_mon.pair_column);
          check_field("chroma_valid", want.chroma_valid, out_mon.chroma_valid);
          check_field("chroma_u_out", want.chroma_u_out, out_mon.chroma_u_out);
          check_field("chroma_v_out", want.chroma_v_out, out_mon.chroma_v_out);
          check_field("chroma_row", want.chroma_row, out_mon.chroma_row);
          check_field("frame_end", want.frame_end, out_mon.frame_end);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        pred = predict_nv12({in_mon.chroma_u_in, in_mon.luma_first_in,
                             in_mon.chroma_v_in, in_mon.luma_second_in});
        nv12_expected_q = {nv12_expected_q, pred};
      end
    end
    pending <= nv12_expected_q.size();
  end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// drives uyvy macropixel beats and frame geometry writes into the converter
// with random gaps and receiver stalls, and reports the checker's verdict
// ----------------------------------------------------------------------------
module tb_top;
  import u2n_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_BEATS = 800;
  localparam int HOLD_CYCLES  = 300;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic              pready;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  int                fail_count;
  int                pending_count;
  int                cycle_count = 0;
  int                in_idle_pct = 0;
  int                out_idle_pct = 0;
  int                sent_random = 0;
  bit                hold_req = 1'b0;

  u2n_in_if  in_ch();
  u2n_out_if out_ch();

  always #4 clk = ~clk;

  uyvy_to_nv12_converter_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  u2n_nv12_checker nv12_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  // beat word is {u, y0, v, y1}
  task automatic send_beat(logic [31:0] w);
    if (in_idle_pct > 0 && $urandom_range(0, 99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    {in_ch.chroma_u_in, in_ch.luma_first_in, in_ch.chroma_v_in, in_ch.luma_second_in} <= w;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  task automatic cfg_write(logic reg_sel, logic [CFG_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_top: errors");
    $finish;
  end

  initial begin : result_sink
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (out_idle_pct > 0 && $urandom_range(0, 99) < out_idle_pct) begin
        out_ch.ready <= 1'b0;
        repeat (pick_gap()) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin : stimulus
    int pairs_v;
    int rows_v;
    int frames;
    int beats;
    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.chroma_u_in    <= '0;
    in_ch.luma_first_in  <= '0;
    in_ch.chroma_v_in    <= '0;
    in_ch.luma_second_in <= '0;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // odd height frame, byte extremes and round-up averages
    in_idle_pct  = 30;
    out_idle_pct = 30;
    cfg_write(REG_PAIRS, 32'd2);
    cfg_write(REG_ROWS, 32'd3);
    send_beat(32'hFF00_00FF);
    send_beat(32'h00FF_FF00);
    send_beat(32'h0080_FF7F);
    send_beat(32'h0100_FEFF);
    send_beat(32'hFFFF_FFFF);
    send_beat(32'h0000_0000);
    drain_results();

    // zero geometry acts as one by one
    cfg_write(REG_PAIRS, 32'h0000_F000);
    cfg_write(REG_ROWS, 32'd0);
    repeat (2) send_beat($urandom);
    drain_results();

    // maximum and clamped geometry, then shrunk mid-frame so counters wrap
    cfg_write(REG_PAIRS, 32'd2048);
    cfg_write(REG_ROWS, 32'hFFFF_FFFF);
    repeat (3) send_beat($urandom);
    drain_results();
    cfg_write(REG_PAIRS, 32'hFFFF_FFFF);
    cfg_write(REG_ROWS, 32'd4096);
    repeat (2) send_beat($urandom);
    drain_results();
    cfg_write(REG_PAIRS, 32'd3);
    repeat (4) send_beat($urandom);
    drain_results();
    cfg_write(REG_ROWS, 32'd1);
    repeat (3) send_beat($urandom);

    while (sent_random < RANDOM_BEATS) begin
      if (sent_random == 0) begin
        pairs_v      = 8;
        rows_v       = 6;
        frames       = 1;
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end else begin
        case ($urandom_range(0, 9))
          0:       pairs_v = 0;
          1, 2:    pairs_v = $urandom_range(7, 40);
          default: pairs_v = $urandom_range(1, 6);
        endcase
        case ($urandom_range(0, 9))
          0:       rows_v = 0;
          1:       rows_v = $urandom_range(7, 12);
          default: rows_v = $urandom_range(1, 6);
        endcase
        frames       = $urandom_range(1, 3);
        in_idle_pct  = 20 * $urandom_range(0, 3);
        out_idle_pct = 20 * $urandom_range(0, 3);
      end
      beats = frames * (pairs_v == 0 ? 1 : pairs_v) * (rows_v == 0 ? 1 : rows_v);
      drain_results();
      cfg_write(REG_PAIRS, ($urandom & 32'hFFFF_F000) | pairs_v);
      cfg_write(REG_ROWS, ($urandom & 32'hFFFF_E000) | rows_v);
      if (sent_random == 0) hold_req = 1'b1;
      repeat (beats) begin
        send_beat($urandom);
        sent_random++;
        if (sent_random == RANDOM_BEATS / 2) drain_results();
      end
    end

    drain_results();
    repeat (4) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
